FILE: hdl/aonrw_pkg.sv
// shared types and constants for the all-or-nothing reader/writer lock manager
`timescale 1ns / 1ps
package aonrw_pkg;

  localparam int COUNT_W = 9;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [1:0] KIND_APPEND  = 2'd0;
  localparam logic [1:0] KIND_GRANT   = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  localparam logic [2:0] STATUS_STORED   = 3'd0;
  localparam logic [2:0] STATUS_GRANTED  = 3'd1;
  localparam logic [2:0] STATUS_WAITING  = 3'd2;
  localparam logic [2:0] STATUS_RELEASED = 3'd3;
  localparam logic [2:0] STATUS_ERROR    = 3'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] worker;
    logic [9:0] item_id;
    logic       is_write;
  } request_t;

  typedef struct packed {
    logic [3:0] worker_out;
    logic [2:0] status;
    logic [9:0] blocking_item;
  } result_t;

  typedef struct packed {
    logic [9:0] item;
    logic       wr;
  } pend_entry_t;

  typedef struct packed {
    logic [COUNT_W-1:0] readers;
    logic [COUNT_W-1:0] writers;
  } count_pair_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PEND,
    ST_COUNT,
    ST_EVAL
  } state_t;

  typedef enum logic [1:0] {
    WALK_CHECK,
    WALK_INC,
    WALK_DEC
  } walk_t;

endpackage

FILE: hdl/aonrw_count_unit.sv
// shared conflict check and saturating count update for one access
`timescale 1ns / 1ps
module aonrw_count_unit (
  input  aonrw_pkg::walk_t       walk,
  input  logic                   wr,
  input  aonrw_pkg::count_pair_t counts,
  output logic                   conflict,
  output aonrw_pkg::count_pair_t counts_next
);
  import aonrw_pkg::*;

  logic [COUNT_W-1:0] sel;
  logic [COUNT_W-1:0] sel_next;

  assign conflict = wr ? ((counts.readers != '0) || (counts.writers != '0))
                       : (counts.writers != '0);
  assign sel = wr ? counts.writers : counts.readers;

  always_comb begin
    case (walk)
      WALK_INC: sel_next = (sel == COUNT_MAX) ? sel : sel + 1'b1;
      WALK_DEC: sel_next = (sel == '0) ? sel : sel - 1'b1;
      default:  sel_next = sel;
    endcase
  end

  always_comb begin
    counts_next = counts;
    if (wr) begin
      counts_next.writers = sel_next;
    end else begin
      counts_next.readers = sel_next;
    end
  end

endmodule

FILE: hdl/all_or_nothing_rw_lock_grant.sv
// top level: all-or-nothing reader/writer lock manager with per-item counts
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  command  | start, busy          | request (kind, worker, item_id, is_write)
//  result   | done (one-cycle)     | result (worker_out, status, blocking_item)
//
// append, error and empty-list commands: result in the next cycle, busy stays low.
// grant: each stored access takes a pending-list read, a count-memory read and an
// evaluate step in the check walk, which stops at the first conflict, and again in the
// count walk, which writes the counts; release does the same in one decrement walk.
// after reset a clearing pass over all entries zeroes the count memory with busy high.
// results cannot be stalled: each is presented for exactly one cycle on done.
`timescale 1ns / 1ps
module all_or_nothing_rw_lock_grant #(
  parameter int WORKERS      = 16,
  parameter int ITEMS        = 1024,
  parameter int MAX_ACCESSES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  aonrw_pkg::request_t request,
  output logic                done,
  output aonrw_pkg::result_t  result
);
  import aonrw_pkg::*;

  localparam int WK_W     = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int ID_W     = $clog2(ITEMS);
  localparam int LEN_W    = $clog2(MAX_ACCESSES + 1);
  localparam int PA_DEPTH = WORKERS * MAX_ACCESSES;
  localparam int PA_W     = (PA_DEPTH > 1) ? $clog2(PA_DEPTH) : 1;

  // memories
  pend_entry_t pend_mem [PA_DEPTH];
  count_pair_t cnt_mem  [ITEMS];
  pend_entry_t pend_rdata;
  count_pair_t cnt_rdata;

  // control state
  state_t            state, state_next;
  walk_t             walk;
  logic [ID_W-1:0]   clear_addr;
  logic [LEN_W-1:0]  list_len [WORKERS];
  logic [WORKERS-1:0] granted_flag;
  logic [WK_W-1:0]   cur_worker;
  logic [3:0]        worker_raw;
  logic [LEN_W-1:0]  len_cur;
  logic [LEN_W-1:0]  idx;
  logic [PA_W-1:0]   base_addr;
  logic [PA_W-1:0]   pend_addr;
  logic              done_next;
  result_t           result_next;

  // command decode
  logic            accept;
  logic [WK_W-1:0] wk;
  logic            cmd_error;
  logic            cmd_append;
  logic            cmd_walk;
  logic            cmd_grant_now;
  logic            cmd_release_now;
  logic [LEN_W-1:0] wk_len;
  logic            wk_granted;
  logic [PA_W-1:0] wk_base;

  // walk signals
  logic            last;
  logic            conflict;
  count_pair_t     counts_next;
  logic [ID_W-1:0] cnt_raddr;
  logic            cnt_we;
  logic [ID_W-1:0] cnt_waddr;
  count_pair_t     cnt_wdata;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign wk     = WK_W'(request.worker);
  assign wk_len = list_len[wk];
  assign wk_granted = granted_flag[wk];
  assign wk_base = PA_W'(32'(wk) * MAX_ACCESSES);

  always_comb begin
    cmd_error       = 1'b0;
    cmd_append      = 1'b0;
    cmd_walk        = 1'b0;
    cmd_grant_now   = 1'b0;
    cmd_release_now = 1'b0;
    if ((32'(request.worker) >= 32'(WORKERS)) || (request.kind == KIND_UNUSED)) begin
      cmd_error = 1'b1;
    end else begin
      case (request.kind)
        KIND_APPEND: begin
          if (wk_granted || (32'(wk_len) >= 32'(MAX_ACCESSES)) ||
              (32'(request.item_id) >= 32'(ITEMS))) begin
            cmd_error = 1'b1;
          end else begin
            cmd_append = 1'b1;
          end
        end
        KIND_GRANT: begin
          if (wk_granted) begin
            cmd_error = 1'b1;
          end else if (wk_len == '0) begin
            cmd_grant_now = 1'b1;
          end else begin
            cmd_walk = 1'b1;
          end
        end
        KIND_RELEASE: begin
          if (!wk_granted) begin
            cmd_error = 1'b1;
          end else if (wk_len == '0) begin
            cmd_release_now = 1'b1;
          end else begin
            cmd_walk = 1'b1;
          end
        end
        default: cmd_error = 1'b1;
      endcase
    end
  end

  assign last      = ({1'b0, idx} + 1'b1) == {1'b0, len_cur};
  assign cnt_raddr = ID_W'(pend_rdata.item);

  aonrw_count_unit u_count_unit (
    .walk        (walk),
    .wr          (pend_rdata.wr),
    .counts      (cnt_rdata),
    .conflict    (conflict),
    .counts_next (counts_next)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clear_addr == ID_W'(ITEMS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && cmd_walk) begin
          state_next = ST_PEND;
        end
      end
      ST_PEND:  state_next = ST_COUNT;
      ST_COUNT: state_next = ST_EVAL;
      ST_EVAL: begin
        if (walk == WALK_CHECK && conflict) begin
          state_next = ST_IDLE;
        end else if (last && walk != WALK_CHECK) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_PEND;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // outputs and memory write control
  always_comb begin
    done_next   = 1'b0;
    result_next = '0;
    cnt_we      = 1'b0;
    cnt_waddr   = cnt_raddr;
    cnt_wdata   = counts_next;
    case (state)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clear_addr;
        cnt_wdata = '0;
      end
      ST_IDLE: begin
        if (accept && !cmd_walk) begin
          done_next              = 1'b1;
          result_next.worker_out = request.worker;
          if (cmd_error) begin
            result_next.status = STATUS_ERROR;
          end else if (cmd_append) begin
            result_next.status = STATUS_STORED;
          end else if (cmd_grant_now) begin
            result_next.status = STATUS_GRANTED;
          end else begin
            result_next.status = STATUS_RELEASED;
          end
        end
      end
      ST_EVAL: begin
        result_next.worker_out = worker_raw;
        if (walk == WALK_CHECK) begin
          if (conflict) begin
            done_next                 = 1'b1;
            result_next.status        = STATUS_WAITING;
            result_next.blocking_item = pend_rdata.item;
          end
        end else begin
          cnt_we = 1'b1;
          if (last) begin
            done_next          = 1'b1;
            result_next.status = (walk == WALK_INC) ? STATUS_GRANTED : STATUS_RELEASED;
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clear_addr   <= '0;
      granted_flag <= '0;
      done         <= 1'b0;
      for (int w = 0; w < WORKERS; w++) begin
        list_len[w] <= '0;
      end
    end else begin
      state <= state_next;
      done  <= done_next;
      if (state == ST_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
      if (state == ST_IDLE && accept) begin
        if (cmd_append) begin
          list_len[wk] <= wk_len + 1'b1;
        end
        if (cmd_grant_now) begin
          granted_flag[wk] <= 1'b1;
        end
        if (cmd_release_now) begin
          granted_flag[wk] <= 1'b0;
          list_len[wk]     <= '0;
        end
      end
      if (state == ST_EVAL && last && walk == WALK_INC) begin
        granted_flag[cur_worker] <= 1'b1;
      end
      if (state == ST_EVAL && last && walk == WALK_DEC) begin
        granted_flag[cur_worker] <= 1'b0;
        list_len[cur_worker]     <= '0;
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    result <= result_next;
    if (state == ST_IDLE && accept && cmd_walk) begin
      cur_worker <= wk;
      worker_raw <= request.worker;
      len_cur    <= wk_len;
      base_addr  <= wk_base;
      pend_addr  <= wk_base;
      idx        <= '0;
      walk       <= (request.kind == KIND_GRANT) ? WALK_CHECK : WALK_DEC;
    end else if (state == ST_EVAL) begin
      if (!last) begin
        idx       <= idx + 1'b1;
        pend_addr <= pend_addr + 1'b1;
      end else if (walk == WALK_CHECK) begin
        walk      <= WALK_INC;
        idx       <= '0;
        pend_addr <= base_addr;
      end
    end
  end

  // pending access lists
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && cmd_append) begin
      pend_mem[PA_W'(32'(wk) * MAX_ACCESSES + 32'(wk_len))] <=
        '{item: request.item_id, wr: request.is_write};
    end
    pend_rdata <= pend_mem[pend_addr];
  end

  // per-item reader and writer counts
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata <= cnt_mem[cnt_raddr];
  end

  a_busy_no_done: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done) else $error("result strobe while a walk is running");

  a_blocking_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != STATUS_WAITING) |-> (result.blocking_item == '0))
    else $error("blocking item set on a non-waiting result");

  a_granted_flag: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == STATUS_GRANTED) |-> granted_flag[WK_W'(result.worker_out)])
    else $error("grant reported without the worker flag set");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL) |-> (idx < len_cur))
    else $error("walk index beyond the stored list");

endmodule
